// ----- rtl/core/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the work-stealing deque core.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int OccBits = 7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_STEAL = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // registered result side of one request, minus the handle itself
  typedef struct packed {
    logic                 valid;
    logic                 has_job;
    status_t              status;
    logic [OccBits-1:0]   occupancy;
  } rsp_t;

endpackage

// ----- rtl/core/work_stealing_deque_core.sv -----
// ----------------------------------------------------------------------------
// work_stealing_deque_core
// Bounded job deque in a ring: push/pop at the bottom, steal from the top.
// ----------------------------------------------------------------------------
// Busy never rises, so a request can be issued on every clock, and its result
// appears on the out_ ports, marked by out_valid, in the cycle right after the
// request edge. The ring is a single-port-write, single-port-read memory with
// a registered read. Results last exactly one cycle and cannot be held off by
// the receiver, so they must be captured when out_valid is high. Ring contents
// are not cleared at reset; index registers start at zero, so the queue is
// empty.
module work_stealing_deque_core #(
  parameter int RING_DEPTH  = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_job_in,
  output logic        out_valid,
  output logic [31:0] out_job_out,
  output logic        out_has_job,
  output logic [1:0]  out_status,
  output logic [6:0]  out_occupancy
);

  localparam int AW = $clog2(RING_DEPTH);

  logic                   req;
  logic                   wr_en;
  logic                   rd_en;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic [HANDLE_BITS-1:0] wr_data;
  logic [HANDLE_BITS-1:0] rd_data_r;
  wsd_pkg::rsp_t          rsp_r;

  assign busy    = 1'b0;
  assign req     = start & ~busy;
  assign wr_data = HANDLE_BITS'(in_job_in);

  wsd_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .op      (in_op),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rsp_r   (rsp_r)
  );

  wsd_ring #(
    .RING_DEPTH  (RING_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ring (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  assign out_valid     = rsp_r.valid;
  assign out_has_job   = rsp_r.has_job;
  assign out_status    = rsp_r.status;
  assign out_occupancy = rsp_r.occupancy;
  // handle is zero unless the request returned a job
  assign out_job_out   = rsp_r.has_job ? 32'(rd_data_r) : '0;

endmodule

// ----- rtl/core/wsd_ring.sv -----
// ----------------------------------------------------------------------------
// wsd_ring
// Job handle ring storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wsd_ring #(
  parameter int RING_DEPTH  = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  input  logic [HANDLE_BITS-1:0]        wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
  output logic [HANDLE_BITS-1:0]        rd_data_r
);

  logic [HANDLE_BITS-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/wsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// wsd_ctrl
// Bottom/top index registers, request decode and result register.
// ----------------------------------------------------------------------------
module wsd_ctrl #(
  parameter int RING_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req,
  input  logic [1:0]                    op,
  output logic                          wr_en,
  output logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  output logic                          rd_en,
  output logic [$clog2(RING_DEPTH)-1:0] rd_addr,
  output wsd_pkg::rsp_t                 rsp_r
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int IW = $clog2(2 * RING_DEPTH);
  localparam logic [IW-1:0] DEPTH_I = IW'(RING_DEPTH);
  localparam logic [IW-1:0] MOD_I   = IW'(2 * RING_DEPTH);
  localparam logic [IW-1:0] LAST_I  = IW'(2 * RING_DEPTH - 1);

  logic [IW-1:0] bot_r, bot_nxt;
  logic [IW-1:0] top_r, top_nxt;
  wsd_pkg::rsp_t rsp_nxt;

  logic [IW-1:0] count, count_nxt;
  logic [IW-1:0] bot_inc, bot_dec, top_inc;
  logic          is_full, is_empty;

  function automatic logic [AW-1:0] ring_addr(input logic [IW-1:0] v);
    ring_addr = (v < DEPTH_I) ? v[AW-1:0] : AW'(v - DEPTH_I);
  endfunction

  function automatic logic [IW-1:0] held(input logic [IW-1:0] b, input logic [IW-1:0] t);
    // MOD_I wraps to zero when the index range is a power of two
    held = (b >= t) ? b - t : b + MOD_I - t;
  endfunction

  always_comb begin
    count    = held(bot_r, top_r);
    is_full  = (count >= DEPTH_I);
    is_empty = (count == '0);
    bot_inc  = (bot_r == LAST_I) ? '0 : bot_r + 1'b1;
    bot_dec  = (bot_r == '0) ? LAST_I : bot_r - 1'b1;
    top_inc  = (top_r == LAST_I) ? '0 : top_r + 1'b1;

    bot_nxt  = bot_r;
    top_nxt  = top_r;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = ring_addr(bot_r);
    rd_addr  = ring_addr(top_r);

    rsp_nxt.valid   = req;
    rsp_nxt.has_job = 1'b0;
    rsp_nxt.status  = wsd_pkg::ST_OK;

    unique case (wsd_pkg::op_t'(op))
      wsd_pkg::OP_PUSH: begin
        if (is_full) begin
          rsp_nxt.status = wsd_pkg::ST_FULL;
        end else begin
          wr_en   = req;
          bot_nxt = bot_inc;
        end
      end
      wsd_pkg::OP_POP: begin
        rd_addr = ring_addr(bot_dec);
        if (is_empty) begin
          rsp_nxt.status = wsd_pkg::ST_EMPTY;
        end else begin
          rd_en           = req;
          bot_nxt         = bot_dec;
          rsp_nxt.has_job = 1'b1;
        end
      end
      wsd_pkg::OP_STEAL: begin
        if (is_empty) begin
          rsp_nxt.status = wsd_pkg::ST_EMPTY;
        end else begin
          rd_en           = req;
          top_nxt         = top_inc;
          rsp_nxt.has_job = 1'b1;
        end
      end
      default: begin
        // unused code: no state change
      end
    endcase

    count_nxt         = held(bot_nxt, top_nxt);
    rsp_nxt.occupancy = wsd_pkg::OccBits'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bot_r         <= '0;
      top_r         <= '0;
      rsp_r.valid   <= 1'b0;
      rsp_r.has_job <= 1'b0;
    end else begin
      if (req) begin
        bot_r <= bot_nxt;
        top_r <= top_nxt;
      end
      rsp_r.valid   <= rsp_nxt.valid;
      rsp_r.has_job <= rsp_nxt.has_job & req;
    end
    if (req) begin
      rsp_r.status    <= rsp_nxt.status;
      rsp_r.occupancy <= rsp_nxt.occupancy;
    end
  end

endmodule

// ----- sim/work_stealing_deque_core_tb.sv -----
// ----------------------------------------------------------------------------
// work_stealing_deque_core_tb
// Self-checking bench for the ring-buffer job deque. A queue of push, pop and
// steal requests with random gaps drives the core. A shadow deque predicts
// every result, and the monitor compares each strobed result with it.
// ----------------------------------------------------------------------------
module work_stealing_deque_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth     = 64;
  localparam int RandReqs  = 800;
  localparam int MaxGap    = 11;
  localparam int ReportMax = 10;

  typedef struct {
    wsd_pkg::op_t op;
    logic [31:0]  job;
    int           gap;
  } deque_req_t;

  typedef struct {
    logic [31:0]                 job;
    logic                        has_job;
    wsd_pkg::status_t            status;
    logic [wsd_pkg::OccBits-1:0] occupancy;
  } deque_rsp_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_op = wsd_pkg::OP_NONE;
  logic [31:0]        in_job_in = '0;
  logic               out_valid;
  logic [31:0]        out_job_out;
  logic               out_has_job;
  logic [1:0]         out_status;
  logic [6:0]         out_occupancy;

  work_stealing_deque_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_job_in    (in_job_in),
    .out_valid    (out_valid),
    .out_job_out  (out_job_out),
    .out_has_job  (out_has_job),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  // shadow copy of the deque
  logic [31:0] ring_shadow [Depth];
  logic [6:0]  bot_shadow = '0;
  logic [6:0]  top_shadow = '0;

  deque_req_t  pending_reqs [$];
  deque_rsp_t  expected_rsps [$];

  int n_err = 0;
  int n_push = 0, n_pop = 0, n_steal = 0, n_ignored = 0;
  int n_full = 0, n_empty = 0, peak_occ = 0, n_checked = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d requests still queued, %0d results outstanding",
             pending_reqs.size(), expected_rsps.size());
    $display("status: fail");
    $finish;
  end

  // applies one accepted request to the shadow deque and returns its result
  function automatic deque_rsp_t deque_apply(wsd_pkg::op_t op, logic [31:0] job);
    deque_rsp_t r;
    logic [6:0] held;
    held        = bot_shadow - top_shadow;
    r.job       = '0;
    r.has_job   = 1'b0;
    r.status    = wsd_pkg::ST_OK;
    case (op)
      wsd_pkg::OP_PUSH: begin
        n_push++;
        if (held >= 7'(Depth)) begin
          r.status = wsd_pkg::ST_FULL;
          n_full++;
        end else begin
          ring_shadow[bot_shadow[5:0]] = job;
          bot_shadow = bot_shadow + 7'd1;
        end
      end
      wsd_pkg::OP_POP: begin
        n_pop++;
        if (held == '0) begin
          r.status = wsd_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          bot_shadow = bot_shadow - 7'd1;
          r.job      = ring_shadow[bot_shadow[5:0]];
          r.has_job  = 1'b1;
        end
      end
      wsd_pkg::OP_STEAL: begin
        n_steal++;
        if (held == '0) begin
          r.status = wsd_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.job      = ring_shadow[top_shadow[5:0]];
          top_shadow = top_shadow + 7'd1;
          r.has_job  = 1'b1;
        end
      end
      default: n_ignored++;
    endcase
    r.occupancy = bot_shadow - top_shadow;
    if (int'(r.occupancy) > peak_occ) peak_occ = int'(r.occupancy);
    return r;
  endfunction

  task automatic add_req(wsd_pkg::op_t op, logic [31:0] job, int gap);
    deque_req_t q;
    q.op  = op;
    q.job = job;
    q.gap = gap;
    pending_reqs.push_back(q);
  endtask

  // driver
  deque_req_t next_req;
  logic       have_next = 1'b0;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      in_op     <= wsd_pkg::OP_NONE;
      in_job_in <= '0;
    end else if (!(start && busy)) begin
      if (start) expected_rsps.push_back(deque_apply(wsd_pkg::op_t'(in_op), in_job_in));
      if (!have_next && pending_reqs.size() > 0) begin
        next_req  = pending_reqs.pop_front();
        have_next = 1'b1;
        gap_left  = next_req.gap;
      end
      if (have_next && gap_left == 0) begin
        start     <= 1'b1;
        in_op     <= next_req.op;
        in_job_in <= next_req.job;
        have_next = 1'b0;
      end else begin
        // junk on the request fields while idle must be ignored
        start     <= 1'b0;
        in_op     <= 2'($urandom);
        in_job_in <= $urandom;
        if (have_next) gap_left--;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    deque_rsp_t e;
    if (rst_n && out_valid) begin
      if (expected_rsps.size() == 0) begin
        n_err++;
        if (n_err <= ReportMax)
          $display("unexpected result: job=%h has_job=%b status=%0d occ=%0d",
                   out_job_out, out_has_job, out_status, out_occupancy);
      end else begin
        e = expected_rsps.pop_front();
        n_checked++;
        if (out_job_out !== e.job || out_has_job !== e.has_job ||
            out_status !== e.status || out_occupancy !== e.occupancy) begin
          n_err++;
          if (n_err <= ReportMax) begin
            $display("mismatch #%0d: exp job=%h has_job=%b status=%0d occ=%0d",
                     n_checked, e.job, e.has_job, e.status, e.occupancy);
            $display("  got job=%h has_job=%b status=%0d occ=%0d",
                     out_job_out, out_has_job, out_status, out_occupancy);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int           real_reqs;
    int           seg_len;
    int           push_pct;
    bit           burst;
    int           pick;
    wsd_pkg::op_t op;

    // directed: empty cases, handle extremes, order checks, unused code
    add_req(wsd_pkg::OP_POP,   '0, 0);
    add_req(wsd_pkg::OP_STEAL, '0, 0);
    add_req(wsd_pkg::OP_PUSH,  32'h0000_0000, 0);
    add_req(wsd_pkg::OP_PUSH,  32'hFFFF_FFFF, 0);
    add_req(wsd_pkg::OP_PUSH,  32'hAAAA_AAAA, 3);
    add_req(wsd_pkg::OP_PUSH,  32'h5555_5555, 0);
    add_req(wsd_pkg::OP_NONE,  32'hDEAD_BEEF, 0);
    add_req(wsd_pkg::OP_POP,   '0, 0);
    add_req(wsd_pkg::OP_STEAL, '0, 1);
    add_req(wsd_pkg::OP_PUSH,  32'h8000_0001, 0);
    add_req(wsd_pkg::OP_STEAL, '0, 0);
    add_req(wsd_pkg::OP_POP,   '0, 0);
    add_req(wsd_pkg::OP_POP,   '0, 2);
    add_req(wsd_pkg::OP_STEAL, '0, 0);
    add_req(wsd_pkg::OP_POP,   '0, 0);
    add_req(wsd_pkg::OP_NONE,  '0, 0);
    add_req(wsd_pkg::OP_PUSH,  32'h1234_5678, 0);
    add_req(wsd_pkg::OP_STEAL, '0, 0);
    add_req(wsd_pkg::OP_STEAL, '0, 0);

    // random: segments biased toward filling, draining or churning the ring
    real_reqs = 0;
    seg_len   = 0;
    push_pct  = 90;
    burst     = 1'b0;
    while (real_reqs < RandReqs) begin
      if (seg_len == 0) begin
        if (real_reqs == 0) begin
          seg_len  = 100;
          push_pct = 90;
        end else begin
          seg_len = $urandom_range(40, 120);
          case ($urandom_range(0, 2))
            0:       push_pct = 88;
            1:       push_pct = 12;
            default: push_pct = 50;
          endcase
        end
        burst = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) op = wsd_pkg::OP_NONE;
      else if (pick < push_pct)      op = wsd_pkg::OP_PUSH;
      else if (pick[0])              op = wsd_pkg::OP_POP;
      else                           op = wsd_pkg::OP_STEAL;
      add_req(op, $urandom, burst ? 0 : $urandom_range(0, MaxGap));
      if (op != wsd_pkg::OP_NONE) real_reqs++;
      seg_len--;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_reqs.size() > 0 || have_next || start);
    while (expected_rsps.size() > 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("covered %0d pushes, %0d pops, %0d steals, %0d ignored requests",
             n_push, n_pop, n_steal, n_ignored);
    $display("%0d dropped on full, %0d on empty, peak occupancy %0d, %0d results checked",
             n_full, n_empty, peak_occ, n_checked);
    if (expected_rsps.size() > 0)
      $display("%0d results never arrived", expected_rsps.size());
    if (n_err == 0 && expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_err);
      $display("status: fail");
    end
    $finish;
  end

endmodule
